// ----- hdl/ntt_polynomial_multiply_defines.svh -----
// assertion helpers used by the control rtl
`ifndef NTT_POLYNOMIAL_MULTIPLY_DEFINES_SVH
`define NTT_POLYNOMIAL_MULTIPLY_DEFINES_SVH

// condition holds at every clock edge out of reset
`define NTTPM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define NTTPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define NTTPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nttpm_pkg.sv -----
`default_nettype none

package nttpm_pkg;

    localparam int MAX_TRANSFORM = 64;
    localparam int MAX_TERMS     = 32;
    localparam int LOG_MAX       = $clog2(MAX_TRANSFORM);
    localparam int CAP_INT       = (MAX_TRANSFORM / 2 < MAX_TERMS) ? MAX_TRANSFORM / 2
                                                                   : MAX_TERMS;

    localparam logic [5:0]  CAP   = 6'(CAP_INT);
    localparam logic [29:0] MODP  = 30'd998244353;
    localparam logic [29:0] ROOT  = 30'd3;
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(MODP));

    // write data sources
    localparam logic [1:0] WSRC_LOAD = 2'd0;
    localparam logic [1:0] WSRC_SUM  = 2'd1;
    localparam logic [1:0] WSRC_DIFF = 2'd2;
    localparam logic [1:0] WSRC_PROD = 2'd3;

    // multiplier operand sources
    localparam logic [1:0] MSRC_BF  = 2'd0;
    localparam logic [1:0] MSRC_PW  = 2'd1;
    localparam logic [1:0] MSRC_OUT = 2'd2;

    typedef logic [29:0] twiddle_t [MAX_TRANSFORM];
    typedef logic [29:0] inv_lim_t [LOG_MAX + 1];

    typedef struct packed {
        logic        we_a;
        logic        we_b;
        logic [5:0]  waddr;
        logic [1:0]  wsrc;
        logic [5:0]  raddr;
        logic        zero_a;
        logic        zero_b;
        logic        vsel;
        logic        inv;
        logic        cap_u;
        logic        cap_t;
        logic        mul_go;
        logic [1:0]  mul_src;
        logic [5:0]  tw_idx;
        logic [2:0]  k;
        logic        emit;
        logic [5:0]  degree;
        logic        final_res;
        logic        overflow;
    } ctrl_cmd_t;

    function automatic logic [29:0] mul_mod_c(input logic [29:0] x, input logic [29:0] y);
        logic [59:0] prod;
        prod = 60'(x) * 60'(y);
        return 30'(prod % 60'(MODP));
    endfunction

    function automatic logic [29:0] pow_mod_c(input logic [29:0] base, input logic [29:0] e);
        logic [29:0] acc;
        logic [29:0] sq;
        acc = 30'd1;
        sq  = base;
        for (int i = 0; i < 30; i++)
        begin
            if (e[i])
            begin
                acc = mul_mod_c(acc, sq);
            end
            sq = mul_mod_c(sq, sq);
        end
        return acc;
    endfunction

    // entry len + i holds w^i, w a primitive 2*len-th root (or its inverse)
    function automatic twiddle_t gen_twiddles(input logic inverse);
        twiddle_t    tab;
        logic [29:0] wn;
        logic [29:0] cur;
        for (int i = 0; i < MAX_TRANSFORM; i++)
        begin
            tab[i] = '0;
        end
        for (int h = 0; (1 << h) < MAX_TRANSFORM; h++)
        begin
            wn = pow_mod_c(ROOT, 30'((MODP - 30'd1) >> (h + 1)));
            if (inverse)
            begin
                wn = pow_mod_c(wn, MODP - 30'd2);
            end
            cur = 30'd1;
            for (int i = 0; i < (1 << h); i++)
            begin
                tab[(1 << h) + i] = cur;
                cur = mul_mod_c(cur, wn);
            end
        end
        return tab;
    endfunction

    function automatic inv_lim_t gen_inv_lim();
        inv_lim_t tab;
        for (int k = 0; k <= LOG_MAX; k++)
        begin
            tab[k] = pow_mod_c(30'((MODP + 30'd1) >> 1), 30'(k));
        end
        return tab;
    endfunction

    localparam twiddle_t TWIDDLE_FWD = gen_twiddles(1'b0);
    localparam twiddle_t TWIDDLE_INV = gen_twiddles(1'b1);
    localparam inv_lim_t INV_LIM     = gen_inv_lim();

endpackage

`default_nettype wire

// ----- hdl/nttpm_ram.sv -----
`default_nettype none

module nttpm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/nttpm_modmul.sv -----
`default_nettype none

// pipelined a*b mod p, barrett reduction; out_valid follows in_valid through a valid shift register
module nttpm_modmul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [29:0] a,
    input  wire logic [29:0] b,
    output logic             out_valid,
    output logic [29:0]      result
);

    logic [5:0]  valid_reg;
    logic [29:0] a_reg;
    logic [29:0] b_reg;
    logic [59:0] z_reg;
    logic [61:0] t_reg;
    logic [31:0] zlo2_reg;
    logic [31:0] zlo3_reg;
    logic [31:0] qp_reg;
    logic [31:0] r_reg;
    logic [29:0] res_reg;
    logic [30:0] q;
    logic [32:0] r_m1;
    logic [32:0] r_m2;

    assign q    = t_reg[61:31];
    assign r_m1 = {1'b0, r_reg} - {3'b0, nttpm_pkg::MODP};
    assign r_m2 = {1'b0, r_reg} - {2'b0, nttpm_pkg::MODP, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a;
        b_reg    <= b;
        z_reg    <= 60'(a_reg) * 60'(b_reg);
        t_reg    <= 62'(z_reg[59:29]) * 62'(nttpm_pkg::BARRETT_MU);
        zlo2_reg <= z_reg[31:0];
        // only the low 32 bits of q*p are needed
        qp_reg   <= 32'(q) * 32'(nttpm_pkg::MODP);
        zlo3_reg <= zlo2_reg;
        r_reg    <= zlo3_reg - qp_reg;
        // remainder is below three times p
        if (!r_m2[32])
        begin
            res_reg <= r_m2[29:0];
        end
        else if (!r_m1[32])
        begin
            res_reg <= r_m1[29:0];
        end
        else
        begin
            res_reg <= r_reg[29:0];
        end
    end

    assign out_valid = valid_reg[5];
    assign result    = res_reg;

endmodule

`default_nettype wire

// ----- hdl/nttpm_datapath.sv -----
`default_nettype none

module nttpm_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nttpm_pkg::ctrl_cmd_t cmd,
    input  wire logic [29:0]          coeff,
    output logic                      mul_done,
    output logic                      result_valid,
    output logic [29:0]               prod_coeff,
    output logic [5:0]                degree,
    output logic                      final_res,
    output logic                      overflow
);

    function automatic logic [29:0] add_mod(input logic [29:0] x, input logic [29:0] y);
        logic [30:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, nttpm_pkg::MODP}) ? 30'(s - {1'b0, nttpm_pkg::MODP}) : s[29:0];
    endfunction

    function automatic logic [29:0] sub_mod(input logic [29:0] x, input logic [29:0] y);
        return (x >= y) ? (x - y) : 30'({1'b0, x} + {1'b0, nttpm_pkg::MODP} - {1'b0, y});
    endfunction

    logic [29:0] rd_a;
    logic [29:0] rd_b;
    logic [29:0] va;
    logic [29:0] vb;
    logic [29:0] vdata;
    logic [29:0] coeff_red;
    logic [29:0] wdata;
    logic [29:0] mul_a;
    logic [29:0] mul_b;
    logic [29:0] mul_res;
    logic        zero_a_reg;
    logic        zero_b_reg;
    logic [29:0] u_reg;
    logic [29:0] t_reg;
    logic [29:0] m_reg;
    logic        result_valid_reg;
    logic [29:0] prod_coeff_reg;
    logic [5:0]  degree_reg;
    logic        final_res_reg;
    logic        overflow_reg;

    nttpm_ram #(.WIDTH(30), .DEPTH(nttpm_pkg::MAX_TRANSFORM)) u_ram_a (
        .clk   (clk),
        .we    (cmd.we_a),
        .waddr (cmd.waddr),
        .wdata (wdata),
        .raddr (cmd.raddr),
        .rdata (rd_a)
    );

    nttpm_ram #(.WIDTH(30), .DEPTH(nttpm_pkg::MAX_TRANSFORM)) u_ram_b (
        .clk   (clk),
        .we    (cmd.we_b),
        .waddr (cmd.waddr),
        .wdata (wdata),
        .raddr (cmd.raddr),
        .rdata (rd_b)
    );

    nttpm_modmul u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.mul_go),
        .a         (mul_a),
        .b         (mul_b),
        .out_valid (mul_done),
        .result    (mul_res)
    );

    // reads flagged by the controller (entries past the fill count) read as zero
    assign va    = zero_a_reg ? '0 : rd_a;
    assign vb    = zero_b_reg ? '0 : rd_b;
    assign vdata = cmd.vsel ? vb : va;

    assign coeff_red = (coeff >= nttpm_pkg::MODP) ? (coeff - nttpm_pkg::MODP) : coeff;

    always_comb
    begin
        case (cmd.mul_src)
            nttpm_pkg::MSRC_BF:
            begin
                mul_a = cmd.inv ? t_reg : sub_mod(u_reg, t_reg);
                mul_b = cmd.inv ? nttpm_pkg::TWIDDLE_INV[cmd.tw_idx]
                                : nttpm_pkg::TWIDDLE_FWD[cmd.tw_idx];
            end
            nttpm_pkg::MSRC_PW:
            begin
                mul_a = va;
                mul_b = vb;
            end
            nttpm_pkg::MSRC_OUT:
            begin
                mul_a = va;
                mul_b = nttpm_pkg::INV_LIM[cmd.k];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // forward stages are decimation in frequency, inverse stages decimation in time
    always_comb
    begin
        case (cmd.wsrc)
            nttpm_pkg::WSRC_LOAD: wdata = coeff_red;
            nttpm_pkg::WSRC_SUM:  wdata = cmd.inv ? add_mod(u_reg, m_reg) : add_mod(u_reg, t_reg);
            nttpm_pkg::WSRC_DIFF: wdata = cmd.inv ? sub_mod(u_reg, m_reg) : m_reg;
            nttpm_pkg::WSRC_PROD: wdata = m_reg;
            default:              wdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        zero_a_reg <= cmd.zero_a;
        zero_b_reg <= cmd.zero_b;
        if (cmd.cap_u)
        begin
            u_reg <= vdata;
        end
        if (cmd.cap_t)
        begin
            t_reg <= vdata;
        end
        if (mul_done)
        begin
            m_reg <= mul_res;
        end
        if (cmd.emit && mul_done)
        begin
            prod_coeff_reg <= mul_res;
            degree_reg     <= cmd.degree;
            final_res_reg  <= cmd.final_res;
            overflow_reg   <= cmd.overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit && mul_done;
        end
    end

    assign result_valid = result_valid_reg;
    assign prod_coeff   = prod_coeff_reg;
    assign degree       = degree_reg;
    assign final_res    = final_res_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire

// ----- hdl/nttpm_ctrl.sv -----
`default_nettype none

module nttpm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            operation,
    input  wire logic            last,
    input  wire logic            mul_done,
    output logic                 busy,
    output nttpm_pkg::ctrl_cmd_t cmd
);

`include "ntt_polynomial_multiply_defines.svh"

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PREP     = 4'd1;
    localparam logic [3:0] S_BF_RA    = 4'd2;
    localparam logic [3:0] S_BF_RB    = 4'd3;
    localparam logic [3:0] S_BF_CAP   = 4'd4;
    localparam logic [3:0] S_BF_MUL   = 4'd5;
    localparam logic [3:0] S_BF_WAIT  = 4'd6;
    localparam logic [3:0] S_BF_WA    = 4'd7;
    localparam logic [3:0] S_BF_WB    = 4'd8;
    localparam logic [3:0] S_PW_RD    = 4'd9;
    localparam logic [3:0] S_PW_MUL   = 4'd10;
    localparam logic [3:0] S_PW_WAIT  = 4'd11;
    localparam logic [3:0] S_PW_WR    = 4'd12;
    localparam logic [3:0] S_OUT_RD   = 4'd13;
    localparam logic [3:0] S_OUT_MUL  = 4'd14;
    localparam logic [3:0] S_OUT_WAIT = 4'd15;

    logic [3:0] state_reg,      state_next;
    logic [5:0] cnt_a_reg,      cnt_a_next;
    logic [5:0] cnt_b_reg,      cnt_b_next;
    logic       first_done_reg, first_done_next;
    logic       ovf_reg,        ovf_next;
    logic [2:0] k_reg,          k_next;
    logic [5:0] plen_reg,       plen_next;
    logic [2:0] h_reg,          h_next;
    logic [4:0] b_reg,          b_next;
    logic [5:0] idx_reg,        idx_next;
    logic       vsel_reg,       vsel_next;
    logic       inv_reg,        inv_next;

    logic [5:0] n_a;
    logic [5:0] n_b;
    logic [5:0] plen_calc;
    logic [2:0] k_calc;
    logic [6:0] lim;
    logic [5:0] lim_m1;
    logic [4:0] half_m1;
    logic [5:0] len;
    logic [5:0] jpart;
    logic [5:0] blk;
    logic [5:0] ia;
    logic [5:0] ib;
    logic       last_bf;
    logic       last_out;
    logic       mask_now;

    assign n_a       = (cnt_a_reg == '0) ? 6'd1 : cnt_a_reg;
    assign n_b       = (cnt_b_reg == '0) ? 6'd1 : cnt_b_reg;
    assign plen_calc = 6'(7'(n_a) + 7'(n_b) - 7'd1);

    always_comb
    begin
        k_calc = 3'(nttpm_pkg::LOG_MAX);
        for (int j = nttpm_pkg::LOG_MAX - 1; j >= 0; j--)
        begin
            if ((7'd1 << j) >= {1'b0, plen_calc})
            begin
                k_calc = 3'(j);
            end
        end
    end

    assign lim     = 7'd1 << k_reg;
    assign lim_m1  = 6'(lim - 7'd1);
    assign half_m1 = 5'((lim >> 1) - 7'd1);

    // butterfly addresses for half-size len = 2^h
    assign len      = 6'd1 << h_reg;
    assign jpart    = {1'b0, b_reg} & (len - 6'd1);
    assign blk      = ({1'b0, b_reg} >> h_reg) << (h_reg + 3'd1);
    assign ia       = blk | jpart;
    assign ib       = ia | len;
    assign last_bf  = (b_reg == half_m1);
    assign last_out = (idx_reg == plen_reg - 6'd1);

    // untouched coefficients are read only in the first forward stage, or in the pointwise pass when k is zero
    assign mask_now = ((state_reg inside {S_BF_RA, S_BF_RB}) && !inv_reg
                       && (h_reg == k_reg - 3'd1))
                   || ((state_reg == S_PW_RD) && (k_reg == '0));

    always_comb
    begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        first_done_next = first_done_reg;
        ovf_next        = ovf_reg;
        k_next          = k_reg;
        plen_next       = plen_reg;
        h_next          = h_reg;
        b_next          = b_reg;
        idx_next        = idx_reg;
        vsel_next       = vsel_reg;
        inv_next        = inv_reg;

        cmd           = '0;
        cmd.vsel      = vsel_reg;
        cmd.inv       = inv_reg;
        cmd.k         = k_reg;
        cmd.tw_idx    = len | jpart;
        cmd.degree    = idx_reg;
        cmd.final_res = last_out;
        cmd.overflow  = ovf_reg;
        cmd.raddr     = (state_reg == S_BF_RA) ? ia : ((state_reg == S_BF_RB) ? ib : idx_reg);
        cmd.zero_a    = mask_now && (cmd.raddr >= cnt_a_reg);
        cmd.zero_b    = mask_now && (cmd.raddr >= cnt_b_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.wsrc = nttpm_pkg::WSRC_LOAD;
                    if (!operation)
                    begin
                        cmd.waddr = cnt_a_reg;
                        if (cnt_a_reg < nttpm_pkg::CAP)
                        begin
                            cmd.we_a   = 1'b1;
                            cnt_a_next = cnt_a_reg + 6'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.waddr = cnt_b_reg;
                        if (cnt_b_reg < nttpm_pkg::CAP)
                        begin
                            cmd.we_b   = 1'b1;
                            cnt_b_next = cnt_b_reg + 6'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (last)
                    begin
                        if (first_done_reg)
                        begin
                            state_next = S_PREP;
                        end
                        else
                        begin
                            first_done_next = 1'b1;
                        end
                    end
                end
            end
            S_PREP:
            begin
                k_next    = k_calc;
                plen_next = plen_calc;
                idx_next  = '0;
                b_next    = '0;
                vsel_next = 1'b0;
                inv_next  = 1'b0;
                h_next    = k_calc - 3'd1;
                state_next = (k_calc == '0) ? S_PW_RD : S_BF_RA;
            end
            S_BF_RA:
            begin
                state_next = S_BF_RB;
            end
            S_BF_RB:
            begin
                cmd.cap_u  = 1'b1;
                state_next = S_BF_CAP;
            end
            S_BF_CAP:
            begin
                cmd.cap_t  = 1'b1;
                state_next = S_BF_MUL;
            end
            S_BF_MUL:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_src = nttpm_pkg::MSRC_BF;
                state_next  = S_BF_WAIT;
            end
            S_BF_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_BF_WA;
                end
            end
            S_BF_WA:
            begin
                cmd.we_a   = !vsel_reg;
                cmd.we_b   = vsel_reg;
                cmd.waddr  = ia;
                cmd.wsrc   = nttpm_pkg::WSRC_SUM;
                state_next = S_BF_WB;
            end
            S_BF_WB:
            begin
                cmd.we_a   = !vsel_reg;
                cmd.we_b   = vsel_reg;
                cmd.waddr  = ib;
                cmd.wsrc   = nttpm_pkg::WSRC_DIFF;
                state_next = S_BF_RA;
                if (!last_bf)
                begin
                    b_next = b_reg + 5'd1;
                end
                else
                begin
                    b_next = '0;
                    if (!inv_reg)
                    begin
                        if (h_reg != '0)
                        begin
                            h_next = h_reg - 3'd1;
                        end
                        else if (!vsel_reg)
                        begin
                            vsel_next = 1'b1;
                            h_next    = k_reg - 3'd1;
                        end
                        else
                        begin
                            vsel_next  = 1'b0;
                            idx_next   = '0;
                            state_next = S_PW_RD;
                        end
                    end
                    else if (h_reg == k_reg - 3'd1)
                    begin
                        idx_next   = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        h_next = h_reg + 3'd1;
                    end
                end
            end
            S_PW_RD:
            begin
                state_next = S_PW_MUL;
            end
            S_PW_MUL:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_src = nttpm_pkg::MSRC_PW;
                state_next  = S_PW_WAIT;
            end
            S_PW_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_PW_WR;
                end
            end
            S_PW_WR:
            begin
                cmd.we_a  = 1'b1;
                cmd.waddr = idx_reg;
                cmd.wsrc  = nttpm_pkg::WSRC_PROD;
                if (idx_reg == lim_m1)
                begin
                    idx_next = '0;
                    if (k_reg == '0)
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        inv_next   = 1'b1;
                        vsel_next  = 1'b0;
                        h_next     = '0;
                        b_next     = '0;
                        state_next = S_BF_RA;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 6'd1;
                    state_next = S_PW_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_src = nttpm_pkg::MSRC_OUT;
                state_next  = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                cmd.emit = 1'b1;
                if (mul_done)
                begin
                    if (last_out)
                    begin
                        cnt_a_next      = '0;
                        cnt_b_next      = '0;
                        first_done_next = 1'b0;
                        ovf_next        = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            first_done_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            k_reg          <= '0;
            plen_reg       <= '0;
            h_reg          <= '0;
            b_reg          <= '0;
            idx_reg        <= '0;
            vsel_reg       <= 1'b0;
            inv_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            first_done_reg <= first_done_next;
            ovf_reg        <= ovf_next;
            k_reg          <= k_next;
            plen_reg       <= plen_next;
            h_reg          <= h_next;
            b_reg          <= b_next;
            idx_reg        <= idx_next;
            vsel_reg       <= vsel_next;
            inv_reg        <= inv_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `NTTPM_ASSERT(a_single_write, !(cmd.we_a && cmd.we_b), "both stores written at once")
    `NTTPM_ASSERT(a_count_cap, (cnt_a_reg <= nttpm_pkg::CAP) && (cnt_b_reg <= nttpm_pkg::CAP),
        "fill count beyond capacity")
    `NTTPM_ASSERT_IMP(a_done_in_wait, mul_done,
        (state_reg == S_BF_WAIT) || (state_reg == S_PW_WAIT) || (state_reg == S_OUT_WAIT),
        "multiplier result outside a wait state")
    `NTTPM_ASSERT_NEXT(a_final_clears, (state_reg == S_OUT_WAIT) && mul_done && last_out,
        (state_reg == S_IDLE) && (cnt_a_reg == '0) && (cnt_b_reg == '0) && !first_done_reg,
        "product end did not clear the block")

endmodule

`default_nettype wire

// ----- hdl/ntt_polynomial_multiply.sv -----
// load: one coefficient transaction per cycle while busy is low
// the closing last mark raises busy; the product run is paced by one shared modular
// multiplier and by single-port reads of the coefficient rams
// results come one at a time, one-cycle strobe, receiver cannot stall
// async active-low reset clears counts, flags and control; ram contents are not reset
`default_nettype none

module ntt_polynomial_multiply (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [29:0] coeff,
    input  wire logic        last,
    output logic             result_valid,
    output logic [29:0]      prod_coeff,
    output logic [5:0]       degree,
    output logic             final_res,
    output logic             overflow
);

    nttpm_pkg::ctrl_cmd_t cmd;
    logic                 mul_done;

    nttpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .last      (last),
        .mul_done  (mul_done),
        .busy      (busy),
        .cmd       (cmd)
    );

    nttpm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .coeff        (coeff),
        .mul_done     (mul_done),
        .result_valid (result_valid),
        .prod_coeff   (prod_coeff),
        .degree       (degree),
        .final_res    (final_res),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire
